// ----- sv/speq_pkg.sv -----
// Package for the sorted event priority queue.
// Holds the item structs, operation and status codes, and the cell control struct.
// No dependencies.
package speq_pkg;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Input item
    typedef struct packed {
        logic        op;
        logic [31:0] in_key;
        logic [31:0] in_tag;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_key;
        logic [31:0] out_tag;
        logic [6:0]  occupancy;
    } t_out_item;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

// ----- sv/speq_cell.sv -----
// One cell of the sorted queue: holds one key and tag.
// Depends on speq_pkg for the control struct.
module speq_cell #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 32,
    parameter int CNT_W    = 7,
    parameter int IDX      = 0
) (
    input  logic                 i_clk,
    input  speq_pkg::t_cell_ctrl i_ctrl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [KEY_BITS-1:0]  i_new_key,
    input  logic [TAG_BITS-1:0]  i_new_tag,
    input  logic                 i_left_le,
    input  logic [KEY_BITS-1:0]  i_left_key,
    input  logic [TAG_BITS-1:0]  i_left_tag,
    input  logic [KEY_BITS-1:0]  i_right_key,
    input  logic [TAG_BITS-1:0]  i_right_tag,
    output logic                 o_le,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [TAG_BITS-1:0]  o_tag
);
    import speq_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic [KEY_BITS-1:0] n_key;
    logic [TAG_BITS-1:0] n_tag;
    logic                w_occ;

    // Occupied cells whose key is not above the new key stay in front of it
    assign w_occ = CNT_W'(IDX) < i_count;
    assign o_le  = w_occ && (r_key <= i_new_key);

    // Choose hold, take the new entry, shift from left, or shift from right
    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctrl.ins) begin
            if (!o_le) begin
                if (i_left_le) begin
                    n_key = i_new_key;
                    n_tag = i_new_tag;
                end else begin
                    n_key = i_left_key;
                    n_tag = i_left_tag;
                end
            end
        end else if (i_ctrl.pop) begin
            n_key = i_right_key;
            n_tag = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

// ----- sv/sorted_event_priority_queue_unit.sv -----
// Top level of the sorted event priority queue: a row of speq_cell cells,
// the entry count and the result register. Depends on speq_pkg and speq_cell.
//
// Entries are kept in ascending key order across a row of DEPTH cells; equal keys
// leave in arrival order. Every cell compares its key with the incoming key at once
// and the whole row shifts together, so an insert or a pop is done in one shift;
// one item is accepted per cycle while input stall is low. The result appears in the
// output register on the cycle after acceptance; input stall rises only while that register
// is full and stalled. An insert into a full queue is dropped with status full; a pop of an
// empty queue returns status empty with zero key and tag.
module sorted_event_priority_queue_unit #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  speq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output speq_pkg::t_out_item o_out_item
);
    import speq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    t_out_item           r_out_item;
    t_out_item           n_out_item;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    t_cell_ctrl          w_ctrl;
    logic [KEY_BITS-1:0] w_new_key;
    logic [TAG_BITS-1:0] w_new_tag;
    logic [DEPTH-1:0]    w_le;
    logic [KEY_BITS-1:0] w_key [DEPTH];
    logic [TAG_BITS-1:0] w_tag [DEPTH];

    // Accept when the result register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = r_count == CNT_W'(DEPTH);
    assign w_empty    = r_count == '0;
    assign w_new_key  = KEY_BITS'(i_in_item.in_key);
    assign w_new_tag  = TAG_BITS'(i_in_item.in_tag);

    // Broadcast the operation to the row; drop it on full or empty
    assign w_ctrl.ins = w_accept && (i_in_item.op == OP_INSERT) && !w_full;
    assign w_ctrl.pop = w_accept && (i_in_item.op == OP_POP) && !w_empty;

    // Build the row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                w_left_le;
        logic [KEY_BITS-1:0] w_left_key;
        logic [TAG_BITS-1:0] w_left_tag;
        logic [KEY_BITS-1:0] w_right_key;
        logic [TAG_BITS-1:0] w_right_tag;

        if (g == 0) begin : g_first
            assign w_left_le  = 1'b1;
            assign w_left_key = w_new_key;
            assign w_left_tag = w_new_tag;
        end else begin : g_mid
            assign w_left_le  = w_le[g-1];
            assign w_left_key = w_key[g-1];
            assign w_left_tag = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_key = w_key[g];
            assign w_right_tag = w_tag[g];
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
            assign w_right_tag = w_tag[g+1];
        end

        speq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_count     (r_count),
            .i_new_key   (w_new_key),
            .i_new_tag   (w_new_tag),
            .i_left_le   (w_left_le),
            .i_left_key  (w_left_key),
            .i_left_tag  (w_left_tag),
            .i_right_key (w_right_key),
            .i_right_tag (w_right_tag),
            .o_le        (w_le[g]),
            .o_key       (w_key[g]),
            .o_tag       (w_tag[g])
        );
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Form the result item
    always_comb begin
        n_out_item         = '0;
        n_out_item.status  = ST_OK;
        if (i_in_item.op == OP_INSERT) begin
            if (w_full) begin
                n_out_item.status = ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_out_item.status = ST_EMPTY;
            end else begin
                n_out_item.out_key = 32'(w_key[0]);
                n_out_item.out_tag = 32'(w_tag[0]);
            end
        end
        n_out_item.occupancy = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result register on every accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in_item.op == OP_INSERT) && w_full
        |=> o_out_item.status == ST_FULL && $stable(r_count))
        else $error("insert on full queue not dropped");

    a_pop_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in_item.op == OP_POP) && !w_empty
        |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not lower the count");

    a_ins_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> r_count == $past(r_count) + 1'b1 && o_out_valid)
        else $error("insert did not raise the count");
`endif

endmodule
